// ===== src/rmq_pkg.sv =====
package rmq_pkg;

   localparam int ELEM_W        = 16;
   localparam int OUT_W         = 16;
   localparam int NUM_W         = ELEM_W + 1;   // sum or difference of two elements
   localparam int Q_W           = OUT_W + 1;    // quotient bits kept before saturation
   localparam int FRAC_BITS_DEF = 14;
   localparam int SAT_MAX       = 32767;
   localparam int SAT_MIN_MAG   = 32768;

   // where s/2 lands; the other three slots take the numerator lanes in order
   typedef enum logic [1:0] {
      SEL_W,
      SEL_X,
      SEL_Y,
      SEL_Z
   } rmq_sel_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] elem_00;
      logic signed [ELEM_W-1:0] elem_01;
      logic signed [ELEM_W-1:0] elem_02;
      logic signed [ELEM_W-1:0] elem_10;
      logic signed [ELEM_W-1:0] elem_11;
      logic signed [ELEM_W-1:0] elem_12;
      logic signed [ELEM_W-1:0] elem_20;
      logic signed [ELEM_W-1:0] elem_21;
      logic signed [ELEM_W-1:0] elem_22;
   } rmq_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] quat_x;
      logic signed [OUT_W-1:0] quat_y;
      logic signed [OUT_W-1:0] quat_z;
      logic signed [OUT_W-1:0] quat_w;
      logic                    degenerate;
   } rmq_rsp_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num0;
      logic signed [NUM_W-1:0] num1;
      logic signed [NUM_W-1:0] num2;
      rmq_sel_type             sel;
      logic                    degen;
   } rmq_side_type;

   typedef struct packed {
      logic [OUT_W-1:0] half;
      rmq_sel_type      sel;
      logic             degen;
   } rmq_tail_type;

   // signed radicand width for a given fraction width
   function automatic int rad_width(input int frac_bits);
      int w;
      w = frac_bits + 2;
      if (w < 19) begin
         w = 19;
      end
      return w;
   endfunction

endpackage

// ===== src/rmq_sqrt.sv =====
module rmq_sqrt
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int X_W       = rad_width(FRAC_BITS) - 1 + FRAC_BITS,
   parameter int S_W       = (X_W + 1) / 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [X_W-1:0]     in_x,
   input  rmq_side_type       in_side,
   output logic               out_valid,
   output logic [S_W-1:0]     out_root,
   output rmq_side_type       out_side
);

   typedef struct packed {
      logic               v;
      logic [S_W+1:0]     rem;
      logic [S_W-1:0]     root;
      logic [2*S_W-1:0]   x;
      rmq_side_type       side;
   } stg_type;

   stg_type head;
   stg_type stg_ff [1:S_W];

   always_comb begin
      head.v    = in_valid;
      head.rem  = '0;
      head.root = '0;
      head.x    = (2*S_W)'(in_x);
      head.side = in_side;
   end

   // one root bit per stage, two radicand bits consumed per stage
   for (genvar g = 1; g <= S_W; g++) begin : g_stage
      stg_type        src;
      stg_type        stg_in;
      logic [S_W+1:0] rsh;
      logic [S_W+1:0] trial;

      if (g == 1) begin : g_first
         assign src = head;
      end else begin : g_rest
         assign src = stg_ff[g-1];
      end

      always_comb begin
         rsh    = {src.rem[S_W-1:0], src.x[2*S_W-1 -: 2]};
         trial  = {src.root, 2'b01};
         stg_in = src;
         stg_in.x = {src.x[2*S_W-3:0], 2'b00};
         if (rsh >= trial) begin
            stg_in.rem  = rsh - trial;
            stg_in.root = {src.root[S_W-2:0], 1'b1};
         end else begin
            stg_in.rem  = rsh;
            stg_in.root = {src.root[S_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[g].v <= 1'b0;
         end else begin
            stg_ff[g] <= stg_in;
         end
      end
   end

   assign out_valid = stg_ff[S_W].v;
   assign out_root  = stg_ff[S_W].root;
   assign out_side  = stg_ff[S_W].side;

endmodule

// ===== src/rmq_div.sv =====
module rmq_div
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int S_W       = (rad_width(FRAC_BITS) - 1 + FRAC_BITS + 1) / 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [S_W-1:0]        in_root,
   input  rmq_side_type          in_side,
   output logic                  out_valid,
   output logic [2:0][OUT_W-1:0] out_quot,
   output rmq_tail_type          out_tail
);

   localparam int DV_W  = NUM_W + FRAC_BITS + 1;
   localparam int D_W   = S_W + 1;
   localparam int R_W   = S_W + 2;
   localparam int CMP_W = (DV_W > D_W + Q_W) ? DV_W : D_W + Q_W;

   typedef struct packed {
      logic                  v;
      logic [D_W-1:0]        d;
      logic [2:0]            neg;
      logic [2:0]            ovf;
      logic [2:0][R_W-1:0]   rem;
      logic [2:0][Q_W-1:0]   lo;
      logic [2:0][Q_W-1:0]   quo;
      rmq_tail_type          tail;
   } dv_type;

   dv_type                  head_in;
   dv_type                  head_ff;
   dv_type                  stg_ff [1:Q_W];
   logic signed [NUM_W-1:0] nums [3];
   logic [NUM_W-1:0]        mag  [3];
   logic [DV_W-1:0]         dvd  [3];
   logic [S_W-1:0]          hw;

   logic                    out_valid_ff;
   logic [2:0][OUT_W-1:0]   quot_ff;
   logic [2:0][OUT_W-1:0]   quot_in;
   rmq_tail_type            tail_ff;

   // dividend = |num| * ONE + S, divisor = 2S, so the quotient is already rounded
   always_comb begin
      nums[0] = in_side.num0;
      nums[1] = in_side.num1;
      nums[2] = in_side.num2;
      hw      = in_root >> 1;
      head_in = '0;
      head_in.v = in_valid;
      head_in.d = {in_root, 1'b0};
      for (int l = 0; l < 3; l++) begin
         head_in.neg[l] = nums[l][NUM_W-1];
         mag[l] = nums[l][NUM_W-1] ? (~nums[l] + 1'b1) : nums[l];
         dvd[l] = (DV_W'(mag[l]) << FRAC_BITS) + DV_W'(in_root);
         head_in.ovf[l] = CMP_W'(dvd[l]) >= (CMP_W'(head_in.d) << Q_W);
         head_in.rem[l] = R_W'(dvd[l] >> Q_W);
         head_in.lo[l]  = dvd[l][Q_W-1:0];
      end
      if (32'(hw) > 32'(SAT_MAX)) begin
         head_in.tail.half = OUT_W'(SAT_MAX);
      end else begin
         head_in.tail.half = OUT_W'(hw);
      end
      head_in.tail.sel   = in_side.sel;
      head_in.tail.degen = in_side.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.v <= 1'b0;
      end else begin
         head_ff <= head_in;
      end
   end

   // restoring division, one quotient bit per stage on all three lanes
   for (genvar g = 1; g <= Q_W; g++) begin : g_stage
      dv_type         src;
      dv_type         stg_in;
      logic [R_W-1:0] rsh [3];

      if (g == 1) begin : g_first
         assign src = head_ff;
      end else begin : g_rest
         assign src = stg_ff[g-1];
      end

      always_comb begin
         stg_in = src;
         for (int l = 0; l < 3; l++) begin
            rsh[l] = {src.rem[l][S_W:0], src.lo[l][Q_W-1]};
            stg_in.lo[l] = {src.lo[l][Q_W-2:0], 1'b0};
            if (rsh[l] >= R_W'(src.d)) begin
               stg_in.rem[l] = rsh[l] - R_W'(src.d);
               stg_in.quo[l] = {src.quo[l][Q_W-2:0], 1'b1};
            end else begin
               stg_in.rem[l] = rsh[l];
               stg_in.quo[l] = {src.quo[l][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[g].v <= 1'b0;
         end else begin
            stg_ff[g] <= stg_in;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (stg_ff[Q_W].neg[l]) begin
            if (stg_ff[Q_W].ovf[l] || stg_ff[Q_W].quo[l] > Q_W'(SAT_MIN_MAG)) begin
               quot_in[l] = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
               quot_in[l] = OUT_W'(~stg_ff[Q_W].quo[l] + 1'b1);
            end
         end else begin
            if (stg_ff[Q_W].ovf[l] || stg_ff[Q_W].quo[l] > Q_W'(SAT_MAX)) begin
               quot_in[l] = OUT_W'(SAT_MAX);
            end else begin
               quot_in[l] = OUT_W'(stg_ff[Q_W].quo[l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= stg_ff[Q_W].v;
      end
      quot_ff <= quot_in;
      tail_ff <= stg_ff[Q_W].tail;
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = quot_ff;
   assign out_tail  = tail_ff;

endmodule

// ===== src/rotation_matrix_to_quaternion_top.sv =====
// Rotation matrix to quaternion, largest-component branch selection, fixed point.
// Request channel: drive req_data (nine signed elements) with start high;
// a request is taken at any clock edge with start high and busy low. busy
// stays low, so a new matrix may enter on every cycle.
// Response channel: rsp_valid is high for exactly one cycle with rsp_data
// holding quat_x/y/z/w and the degenerate flag. The receiver cannot stall;
// every response must be captured in the cycle it is shown.
// Pipeline: an input register, then S_W square-root stages, where S_W =
// ceil((RAD_W-1+FRAC_BITS)/2) (one root bit per stage), then the divider
// head register, Q_W = 17 divider stages (one quotient bit per stage, three
// lanes side by side), the divider output register and the response register.
// Throughput: one matrix per cycle, set by the fully pipelined root and
// divider stages.
// Reset clears all valid bits; requests in flight are dropped and no
// response appears until new requests pass through the pipeline.
// A non-positive radicand gives the identity quaternion with degenerate set.
module rotation_matrix_to_quaternion_top
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rmq_req_type req_data,
   output logic        rsp_valid,
   output rmq_rsp_type rsp_data
);

   localparam int RAD_W = rad_width(FRAC_BITS);
   localparam int X_W   = RAD_W - 1 + FRAC_BITS;
   localparam int S_W   = (X_W + 1) / 2;
   localparam int TR_W  = ELEM_W + 2;
   localparam int LAT   = S_W + Q_W + 4;
   localparam logic signed [RAD_W-1:0] ONE_R = RAD_W'(1) << FRAC_BITS;
   localparam logic [OUT_W-1:0] W_ONE =
      (FRAC_BITS >= OUT_W - 1) ? OUT_W'(SAT_MAX) : OUT_W'(1 << FRAC_BITS);

   logic                    accept;
   logic signed [TR_W-1:0]  trace;
   logic                    pos;
   logic [1:0]              axis;
   logic signed [RAD_W-1:0] rad_pos;
   logic signed [RAD_W-1:0] rad_ax;
   logic signed [RAD_W-1:0] rad_sel;
   rmq_side_type            side_in;

   logic                    a_valid_ff;
   logic [RAD_W-2:0]        a_rad_ff;
   logic [RAD_W-2:0]        a_rad_in;
   rmq_side_type            a_side_ff;

   logic                    sq_valid;
   logic [S_W-1:0]          sq_root;
   rmq_side_type            sq_side;

   logic                    dv_valid;
   logic [2:0][OUT_W-1:0]   dv_quot;
   rmq_tail_type            dv_tail;

   logic                    rsp_valid_ff;
   rmq_rsp_type             rsp_ff;
   rmq_rsp_type             rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // branch choice, radicand and the three numerators
   always_comb begin
      trace = TR_W'(req_data.elem_00) + TR_W'(req_data.elem_11) + TR_W'(req_data.elem_22);
      pos   = trace > 0;
      axis  = 2'd0;
      if (req_data.elem_11 > req_data.elem_00) begin
         axis = 2'd1;
      end
      if (req_data.elem_22 > ((axis == 2'd1) ? req_data.elem_11 : req_data.elem_00)) begin
         axis = 2'd2;
      end
      rad_pos = RAD_W'(trace) + ONE_R;
      side_in = '0;
      if (pos) begin
         side_in.sel  = SEL_W;
         side_in.num0 = NUM_W'(req_data.elem_12) - NUM_W'(req_data.elem_21);
         side_in.num1 = NUM_W'(req_data.elem_20) - NUM_W'(req_data.elem_02);
         side_in.num2 = NUM_W'(req_data.elem_01) - NUM_W'(req_data.elem_10);
      end
      unique case (axis)
         2'd1: begin
            rad_ax = ONE_R + RAD_W'(req_data.elem_11) - RAD_W'(req_data.elem_22)
                     - RAD_W'(req_data.elem_00);
            if (!pos) begin
               side_in.sel  = SEL_Y;
               side_in.num0 = NUM_W'(req_data.elem_12) + NUM_W'(req_data.elem_21);
               side_in.num1 = NUM_W'(req_data.elem_10) + NUM_W'(req_data.elem_01);
               side_in.num2 = NUM_W'(req_data.elem_20) - NUM_W'(req_data.elem_02);
            end
         end
         2'd2: begin
            rad_ax = ONE_R + RAD_W'(req_data.elem_22) - RAD_W'(req_data.elem_00)
                     - RAD_W'(req_data.elem_11);
            if (!pos) begin
               side_in.sel  = SEL_Z;
               side_in.num0 = NUM_W'(req_data.elem_20) + NUM_W'(req_data.elem_02);
               side_in.num1 = NUM_W'(req_data.elem_21) + NUM_W'(req_data.elem_12);
               side_in.num2 = NUM_W'(req_data.elem_01) - NUM_W'(req_data.elem_10);
            end
         end
         default: begin
            rad_ax = ONE_R + RAD_W'(req_data.elem_00) - RAD_W'(req_data.elem_11)
                     - RAD_W'(req_data.elem_22);
            if (!pos) begin
               side_in.sel  = SEL_X;
               side_in.num0 = NUM_W'(req_data.elem_01) + NUM_W'(req_data.elem_10);
               side_in.num1 = NUM_W'(req_data.elem_02) + NUM_W'(req_data.elem_20);
               side_in.num2 = NUM_W'(req_data.elem_12) - NUM_W'(req_data.elem_21);
            end
         end
      endcase
      rad_sel       = pos ? rad_pos : rad_ax;
      side_in.degen = !pos && (rad_ax[RAD_W-1] || rad_ax == '0);
      a_rad_in      = side_in.degen ? '0 : rad_sel[RAD_W-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_rad_ff  <= a_rad_in;
      a_side_ff <= side_in;
   end

   rmq_sqrt #(
      .FRAC_BITS (FRAC_BITS),
      .X_W       (X_W),
      .S_W       (S_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_x      ({a_rad_ff, {FRAC_BITS{1'b0}}}),
      .in_side   (a_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div #(
      .FRAC_BITS (FRAC_BITS),
      .S_W       (S_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_tail  (dv_tail)
   );

   // route s/2 and the three quotients to their quaternion slots
   always_comb begin
      rsp_in.degenerate = dv_tail.degen;
      unique case (dv_tail.sel)
         SEL_X: begin
            rsp_in.quat_x = dv_tail.half;
            rsp_in.quat_y = dv_quot[0];
            rsp_in.quat_z = dv_quot[1];
            rsp_in.quat_w = dv_quot[2];
         end
         SEL_Y: begin
            rsp_in.quat_y = dv_tail.half;
            rsp_in.quat_z = dv_quot[0];
            rsp_in.quat_x = dv_quot[1];
            rsp_in.quat_w = dv_quot[2];
         end
         SEL_Z: begin
            rsp_in.quat_z = dv_tail.half;
            rsp_in.quat_x = dv_quot[0];
            rsp_in.quat_y = dv_quot[1];
            rsp_in.quat_w = dv_quot[2];
         end
         default: begin
            rsp_in.quat_w = dv_tail.half;
            rsp_in.quat_x = dv_quot[0];
            rsp_in.quat_y = dv_quot[1];
            rsp_in.quat_z = dv_quot[2];
         end
      endcase
      if (dv_tail.degen) begin
         rsp_in.quat_x = '0;
         rsp_in.quat_y = '0;
         rsp_in.quat_z = '0;
         rsp_in.quat_w = W_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request did not produce a response after pipeline latency");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("response without a matching request");

   a_degen_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
         (rsp_data.quat_x == '0 && rsp_data.quat_y == '0 &&
          rsp_data.quat_z == '0 && rsp_data.quat_w == W_ONE))
      else $error("degenerate response is not the identity quaternion");
`endif

endmodule
